// ----- rtl/core/lem_pkg.sv -----
// shared types and constants for the leaf elimination matching unit
`timescale 1ns / 1ps
package lem_pkg;

  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] neighbor_node;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] leaf_node;
    logic [NODE_W-1:0] partner_node;
    logic              none_found;
    logic              list_overflow;
    logic              last;
  } out_t;

  typedef struct packed {
    logic              push;
    logic [NODE_W-1:0] push_node;
    logic              pop;
    logic              clear;
  } fifo_ctl_t;

endpackage

// ----- rtl/core/leaf_elimination_matching_unit.sv -----
// top level: load handling, run sequencer, degree and removal tables
`timescale 1ns / 1ps
// Load requests (op = 0) are accepted in idle, then busy stays high in the
// load state while the list length is read and the entry is stored, so a new
// request is taken once the block is back in idle. A run request (op = 1)
// holds busy high while the sequencer walks the graph through the adjacency
// store: it reads the list length of each effective node to seed the leaf
// queue, pops the queue and checks each popped leaf, scans the leaf's
// adjacency entries for a partner until one is found or the list ends,
// fetches the partner's list length, walks the partner's entries and
// decrements each one that is still live, ends that list, and ends with a
// pop of the empty queue followed by a closing state. Results appear on out_res
// with out_strobe high for one cycle each, in the order pairs are found; the
// receiver cannot stall, so it must take every strobe. The last result of a
// run carries last = 1, and a run with no pair gives a single none_found
// result. node_count is written via cfg_we / cfg_wdata only while busy is low;
// the user must keep to this, as the block does not enforce it.
module leaf_elimination_matching_unit #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_DEGREE = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lem_pkg::in_t                in_req,
  output logic                        out_strobe,
  output lem_pkg::out_t               out_res,
  input  logic                        cfg_we,
  input  logic [lem_pkg::CNT_W-1:0]   cfg_wdata
);
  import lem_pkg::*;

  // node ids never exceed the 6-bit field, so slots cap at 64
  localparam int SLOTS  = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int DW     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int LEN_W  = $clog2(MAX_DEGREE + 1);
  localparam int AW     = SLOT_W + DW;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_LOAD     = 14'b00000000000010,
    S_INIT     = 14'b00000000000100,
    S_SEED     = 14'b00000000001000,
    S_POP      = 14'b00000000010000,
    S_LEAF     = 14'b00000000100000,
    S_LCHK     = 14'b00000001000000,
    S_SCAN     = 14'b00000010000000,
    S_SCAN_CHK = 14'b00000100000000,
    S_PLEN     = 14'b00001000000000,
    S_DEC      = 14'b00010000000000,
    S_DEC_CHK  = 14'b00100000000000,
    S_DEC_WR   = 14'b01000000000000,
    S_FINISH   = 14'b10000000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   node_count_r;
  logic [CNT_W-1:0]   n_eff;
  logic [LEN_W-1:0]   len_mem_r [SLOTS];
  logic [LEN_W-1:0]   deg_mem_r [SLOTS];
  logic [SLOTS-1:0]   len_vld_r;
  logic [LEN_W-1:0]   len_rd_r;
  logic               len_vld_rd_r;
  logic [LEN_W-1:0]   deg_rd_r;
  logic [SLOTS-1:0]   rem_r;
  logic               ovf_r;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [LEN_W-1:0]   j_r, j_nxt;
  logic [LEN_W-1:0]   lim_r, lim_nxt;
  logic [NODE_W-1:0]  leaf_r, leaf_nxt;
  logic [NODE_W-1:0]  partner_r, partner_nxt;
  logic [NODE_W-1:0]  v_r, v_nxt;
  logic [NODE_W-1:0]  ld_node_r, ld_nbr_r;
  logic [NODE_W-1:0]  pend_leaf_r, pend_partner_r;
  logic               pend_vld_r;
  out_t               out_res_r;
  logic               out_strobe_r;

  fifo_ctl_t          fctl;
  logic               f_empty;
  logic [NODE_W-1:0]  f_q;
  logic [NODE_W-1:0]  adj_q;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;

  logic [SLOT_W-1:0]  ld_i, fq_i, lf_i, pt_i, v_i, vr_i, in_i;
  logic [SLOT_W-1:0]  len_ra, deg_ra;
  logic               load_go, load_ok, load_bad, run_go;
  logic               v_ok, found, dec_live;
  logic [LEN_W-1:0]   lenv;
  logic [LEN_W-1:0]   nd;

  assign n_eff = (int'(node_count_r) > SLOTS) ? CNT_W'(SLOTS) : node_count_r;

  assign ld_i = ld_node_r[SLOT_W-1:0];
  assign fq_i = f_q[SLOT_W-1:0];
  assign lf_i = leaf_r[SLOT_W-1:0];
  assign pt_i = partner_r[SLOT_W-1:0];
  assign v_i  = adj_q[SLOT_W-1:0];
  assign vr_i = v_r[SLOT_W-1:0];
  assign in_i = i_r[SLOT_W-1:0];

  // a list never loaded since the last run reads as empty
  assign lenv = len_vld_rd_r ? len_rd_r : '0;

  assign run_go   = (state_r == S_IDLE) && start && (in_req.op == OP_RUN);
  assign load_go  = (state_r == S_IDLE) && start && (in_req.op == OP_LOAD);
  assign load_ok  = (state_r == S_LOAD)
                    && ({1'b0, ld_node_r} < n_eff)
                    && ({1'b0, ld_nbr_r} < n_eff)
                    && (lenv < LEN_W'(MAX_DEGREE));
  assign load_bad = (state_r == S_LOAD) && !load_ok;

  assign waddr = {ld_i, lenv[DW-1:0]};

  assign v_ok     = {1'b0, adj_q} < n_eff;
  assign found    = (state_r == S_SCAN_CHK) && v_ok && (adj_q != leaf_r) && !rem_r[v_i];
  assign dec_live = (state_r == S_DEC_CHK) && v_ok && !rem_r[v_i];
  assign nd       = (deg_rd_r == '0) ? '0 : deg_rd_r - 1'b1;

  assign raddr  = (state_r == S_DEC) ? {pt_i, j_r[DW-1:0]} : {lf_i, j_r[DW-1:0]};
  assign deg_ra = (state_r == S_LEAF) ? fq_i : v_i;

  always_comb begin
    priority if (state_r == S_INIT) begin
      len_ra = in_i;
    end else if (state_r == S_LEAF) begin
      len_ra = fq_i;
    end else if (state_r == S_SCAN_CHK) begin
      len_ra = v_i;
    end else begin
      len_ra = in_req.node[SLOT_W-1:0];
    end
  end

  always_comb begin
    fctl.clear     = run_go;
    fctl.push      = 1'b0;
    fctl.push_node = v_r;
    fctl.pop       = (state_r == S_POP);
    if ((state_r == S_SEED) && (lenv == LEN_W'(1))) begin
      fctl.push      = 1'b1;
      fctl.push_node = i_r[NODE_W-1:0];
    end else if ((state_r == S_DEC_WR) && (nd == LEN_W'(1))) begin
      fctl.push = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    lim_nxt     = lim_r;
    leaf_nxt    = leaf_r;
    partner_nxt = partner_r;
    v_nxt       = v_r;
    unique case (state_r)
      S_IDLE: begin
        if (run_go) begin
          state_nxt = S_INIT;
          i_nxt     = '0;
        end else if (load_go) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        state_nxt = (i_r == n_eff) ? S_POP : S_SEED;
      end
      S_SEED: begin
        i_nxt     = i_r + 1'b1;
        state_nxt = S_INIT;
      end
      S_POP: begin
        state_nxt = f_empty ? S_FINISH : S_LEAF;
      end
      S_LEAF: begin
        leaf_nxt  = f_q;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        lim_nxt = lenv;
        j_nxt   = '0;
        if (rem_r[lf_i] || (deg_rd_r != LEN_W'(1))) state_nxt = S_POP;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        state_nxt = (j_r == lim_r) ? S_POP : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (found) begin
          partner_nxt = adj_q;
          state_nxt   = S_PLEN;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_PLEN: begin
        lim_nxt   = lenv;
        j_nxt     = '0;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = (j_r == lim_r) ? S_POP : S_DEC_CHK;
      end
      S_DEC_CHK: begin
        if (dec_live) begin
          v_nxt     = adj_q;
          state_nxt = S_DEC_WR;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC_WR: begin
        j_nxt     = j_r + 1'b1;
        state_nxt = S_DEC;
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= CNT_W'(64);
      ovf_r        <= 1'b0;
      rem_r        <= '0;
      len_vld_r    <= '0;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (found && pend_vld_r) || (state_r == S_FINISH);
      if (cfg_we) node_count_r <= cfg_wdata;
      if (load_bad) ovf_r <= 1'b1;
      if (load_ok) len_vld_r[ld_i] <= 1'b1;
      if (found) begin
        rem_r[lf_i] <= 1'b1;
        rem_r[v_i]  <= 1'b1;
        pend_vld_r  <= 1'b1;
      end
      if (state_r == S_FINISH) begin
        pend_vld_r <= 1'b0;
        ovf_r      <= 1'b0;
        rem_r      <= '0;
        len_vld_r  <= '0;
      end
    end
  end

  // list length and degree tables, registered reads
  always_ff @(posedge clk) begin
    if (load_ok) len_mem_r[ld_i] <= lenv + 1'b1;
    len_rd_r     <= len_mem_r[len_ra];
    len_vld_rd_r <= len_vld_r[len_ra];
    if (state_r == S_SEED) deg_mem_r[in_i] <= lenv;
    if (state_r == S_DEC_WR) deg_mem_r[vr_i] <= nd;
    deg_rd_r <= deg_mem_r[deg_ra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    lim_r     <= lim_nxt;
    leaf_r    <= leaf_nxt;
    partner_r <= partner_nxt;
    v_r       <= v_nxt;
    if (load_go) begin
      ld_node_r <= in_req.node;
      ld_nbr_r  <= in_req.neighbor_node;
    end
    if (found) begin
      pend_leaf_r    <= leaf_r;
      pend_partner_r <= adj_q;
      // previous pair goes out now that a later one exists
      out_res_r.leaf_node     <= pend_leaf_r;
      out_res_r.partner_node  <= pend_partner_r;
      out_res_r.none_found    <= 1'b0;
      out_res_r.list_overflow <= ovf_r;
      out_res_r.last          <= 1'b0;
    end
    if (state_r == S_FINISH) begin
      out_res_r.leaf_node     <= pend_vld_r ? pend_leaf_r : '0;
      out_res_r.partner_node  <= pend_vld_r ? pend_partner_r : '0;
      out_res_r.none_found    <= !pend_vld_r;
      out_res_r.list_overflow <= ovf_r;
      out_res_r.last          <= 1'b1;
    end
  end

  lem_adj_mem #(
    .ADDR_W(AW)
  ) u_adj (
    .clk  (clk),
    .we   (load_ok),
    .waddr(waddr),
    .wdata(ld_nbr_r),
    .raddr(raddr),
    .rdata(adj_q)
  );

  lem_leaf_fifo #(
    .DEPTH(SLOTS)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (fctl),
    .empty(f_empty),
    .rdata(f_q)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// ----- rtl/core/lem_adj_mem.sv -----
// adjacency store, one write and one registered read per cycle
`timescale 1ns / 1ps
module lem_adj_mem #(
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [lem_pkg::NODE_W-1:0] wdata,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [lem_pkg::NODE_W-1:0] rdata
);
  import lem_pkg::*;

  logic [NODE_W-1:0] mem_r [1<<ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/core/lem_leaf_fifo.sv -----
// leaf queue with registered read port
`timescale 1ns / 1ps
module lem_leaf_fifo #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lem_pkg::fifo_ctl_t         ctl,
  output logic                       empty,
  output logic [lem_pkg::NODE_W-1:0] rdata
);
  import lem_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [NODE_W-1:0] mem_r [DEPTH];
  logic [PW:0]       head_r, head_nxt;
  logic [PW:0]       tail_r, tail_nxt;

  assign empty = (head_r == tail_r);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (ctl.push) tail_nxt = tail_r + 1'b1;
      if (ctl.pop && !empty) head_nxt = head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) begin
      mem_r[tail_r[PW-1:0]] <= ctl.push_node;
    end
    if (ctl.pop) begin
      rdata <= mem_r[head_r[PW-1:0]];
    end
  end

endmodule
